// File: src/terminal_key_decoder_defines.svh
// Assertion macros used by the checks in the top-level decoder file.
`ifndef TERMINAL_KEY_DECODER_DEFINES_SVH
`define TERMINAL_KEY_DECODER_DEFINES_SVH

`define TKD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define TKD_ASSERT_NORST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/tkd_pkg.sv
package tkd_pkg;

    localparam int PARAM_CAP = 1000;
    localparam int PARAM_W   = $clog2(PARAM_CAP + 1);
    typedef logic [PARAM_W-1:0] t_param;

    localparam logic [4:0] EV_CHAR        = 5'd0;
    localparam logic [4:0] EV_PASTE_TEXT  = 5'd1;
    localparam logic [4:0] EV_ENTER       = 5'd2;
    localparam logic [4:0] EV_BACKSPACE   = 5'd3;
    localparam logic [4:0] EV_INTERRUPT   = 5'd4;
    localparam logic [4:0] EV_EOF         = 5'd5;
    localparam logic [4:0] EV_HOME        = 5'd6;
    localparam logic [4:0] EV_END         = 5'd7;
    localparam logic [4:0] EV_LEFT        = 5'd8;
    localparam logic [4:0] EV_RIGHT       = 5'd9;
    localparam logic [4:0] EV_UP          = 5'd10;
    localparam logic [4:0] EV_DOWN        = 5'd11;
    localparam logic [4:0] EV_KILL_START  = 5'd12;
    localparam logic [4:0] EV_KILL_END    = 5'd13;
    localparam logic [4:0] EV_KILL_WORD   = 5'd14;
    localparam logic [4:0] EV_CLEAR       = 5'd15;
    localparam logic [4:0] EV_IGNORED     = 5'd16;
    localparam logic [4:0] EV_WORD_RIGHT  = 5'd17;
    localparam logic [4:0] EV_WORD_LEFT   = 5'd18;
    localparam logic [4:0] EV_DELETE      = 5'd19;
    localparam logic [4:0] EV_PASTE_START = 5'd20;
    localparam logic [4:0] EV_PASTE_END   = 5'd21;
    localparam logic [4:0] EV_PASTE_LINE  = 5'd22;

    localparam logic [7:0] B_ESC   = 8'h1b;
    localparam logic [7:0] B_CR    = 8'h0d;
    localparam logic [7:0] B_LF    = 8'h0a;
    localparam logic [7:0] B_TAB   = 8'h09;
    localparam logic [7:0] B_SPACE = 8'h20;

    localparam logic [4:0] TAB_RESET = 5'd8;

    // One command: an optional run of held bytes, then an optional repeated tail event.
    typedef struct packed {
        logic [2:0]      pre_cnt;
        logic            pre_paste;
        logic [4:0][7:0] pre_bytes;
        logic            tail_en;
        logic [4:0]      tail_code;
        logic [7:0]      tail_byte;
        logic [4:0]      tail_rep;
    } t_cmd;

    function automatic logic [7:0] f_marker(logic [2:0] idx);
        logic [7:0] m;
        unique case (idx)
            3'd0: m = B_ESC;
            3'd1: m = 8'h5b;
            3'd2: m = 8'h32;
            3'd3: m = 8'h30;
            3'd4: m = 8'h31;
            3'd5: m = 8'h7e;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

endpackage

// File: src/tkd_front.sv
module tkd_front
    import tkd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_in_byte,
    input  logic       i_cfg_we,
    input  logic [4:0] i_cfg_data,
    output t_cmd       o_cmd,
    output logic       o_has
);

    localparam logic [2:0] M_GROUND = 3'd0;
    localparam logic [2:0] M_ESC    = 3'd1;
    localparam logic [2:0] M_UTF8   = 3'd2;
    localparam logic [2:0] M_CSI    = 3'd3;
    localparam logic [2:0] M_SS3    = 3'd4;

    logic [4:0]      r_tab;
    logic [2:0]      r_mode, n_mode;
    t_param          r_p1, n_p1, r_p2, n_p2;
    logic [1:0]      r_slot, n_slot;
    logic            r_odd, n_odd;
    logic [2:0][7:0] r_held, n_held;
    logic [1:0]      r_cnt, n_cnt;
    logic [1:0]      r_owed, n_owed;
    logic            r_paste, n_paste;
    logic [2:0]      r_match, n_match;
    logic            r_cr, n_cr;

    logic [4:0] tabn;
    logic       do_g, do_f, crb;
    logic [7:0] b;
    t_cmd       cmd;

    function automatic t_param f_next_digit(t_param p, logic [3:0] d);
        logic [PARAM_W+3:0] v;
        v = ({4'd0, p} * (PARAM_W+4)'(10)) + {{PARAM_W{1'b0}}, d};
        if (p >= t_param'(PARAM_CAP) || v > (PARAM_W+4)'(PARAM_CAP)) begin
            return t_param'(PARAM_CAP);
        end
        return v[PARAM_W-1:0];
    endfunction

    function automatic t_cmd f_key(logic [4:0] code);
        t_cmd c;
        c = '0;
        c.tail_en   = 1'b1;
        c.tail_code = code;
        c.tail_rep  = 5'd1;
        return c;
    endfunction

    function automatic logic f_lead(logic [7:0] v);
        return ((v & 8'hE0) == 8'hC0) || ((v & 8'hF0) == 8'hE0) || ((v & 8'hF8) == 8'hF0);
    endfunction

    function automatic t_cmd f_ground(logic [7:0] v, logic [4:0] tn);
        t_cmd c;
        c = '0;
        unique case (v)
            8'h1b: c = '0;
            8'h0d, 8'h0a: c = f_key(EV_ENTER);
            8'h7f, 8'h08: c = f_key(EV_BACKSPACE);
            8'h03: c = f_key(EV_INTERRUPT);
            8'h04: c = f_key(EV_EOF);
            8'h01: c = f_key(EV_HOME);
            8'h05: c = f_key(EV_END);
            8'h02: c = f_key(EV_LEFT);
            8'h06: c = f_key(EV_RIGHT);
            8'h10: c = f_key(EV_UP);
            8'h0e: c = f_key(EV_DOWN);
            8'h15: c = f_key(EV_KILL_START);
            8'h0b: c = f_key(EV_KILL_END);
            8'h17: c = f_key(EV_KILL_WORD);
            8'h0c: c = f_key(EV_CLEAR);
            8'h09: begin
                c = f_key(EV_CHAR);
                c.tail_byte = B_SPACE;
                c.tail_rep  = tn;
            end
            default: begin
                if (v < 8'h20) begin
                    c = f_key(EV_IGNORED);
                end else if (v < 8'h80) begin
                    c = f_key(EV_CHAR);
                    c.tail_byte = v;
                end else if (f_lead(v)) begin
                    c = '0;
                end else begin
                    c = f_key(EV_IGNORED);
                end
            end
        endcase
        return c;
    endfunction

    function automatic t_cmd f_final(logic [7:0] v, logic odd, logic ctl, t_param p1);
        t_cmd c;
        c = f_key(EV_IGNORED);
        if (!odd) begin
            unique case (v)
                8'h41: c = f_key(EV_UP);
                8'h42: c = f_key(EV_DOWN);
                8'h43: c = f_key(ctl ? EV_WORD_RIGHT : EV_RIGHT);
                8'h44: c = f_key(ctl ? EV_WORD_LEFT : EV_LEFT);
                8'h48: c = f_key(EV_HOME);
                8'h46: c = f_key(EV_END);
                8'h7e: begin
                    if (p1 == t_param'(1) || p1 == t_param'(7)) begin
                        c = f_key(EV_HOME);
                    end else if (p1 == t_param'(4) || p1 == t_param'(8)) begin
                        c = f_key(EV_END);
                    end else if (p1 == t_param'(3)) begin
                        c = f_key(EV_DELETE);
                    end else if (p1 == t_param'(200)) begin
                        c = f_key(EV_PASTE_START);
                    end
                end
                default: c = f_key(EV_IGNORED);
            endcase
        end
        return c;
    endfunction

    assign tabn = (r_tab == 5'd0) ? 5'd1 : ((r_tab > 5'd16) ? 5'd16 : r_tab);
    assign b    = i_in_byte;

    always_comb begin
        n_mode  = r_mode;
        n_p1    = r_p1;
        n_p2    = r_p2;
        n_slot  = r_slot;
        n_odd   = r_odd;
        n_held  = r_held;
        n_cnt   = r_cnt;
        n_owed  = r_owed;
        n_paste = r_paste;
        n_match = r_match;
        n_cr    = r_cr;
        cmd     = '0;
        do_g    = 1'b0;
        do_f    = 1'b0;
        crb     = r_cr;
        if (r_paste) begin
            if (r_match < 3'd6 && b == f_marker(r_match)) begin
                if (r_match == 3'd5) begin
                    cmd     = f_key(EV_PASTE_END);
                    n_paste = 1'b0;
                    n_match = 3'd0;
                    n_cr    = 1'b0;
                end else begin
                    n_match = r_match + 3'd1;
                end
            end else begin
                if (r_match != 3'd0) begin
                    cmd.pre_cnt   = r_match;
                    cmd.pre_paste = 1'b1;
                    for (int i = 0; i < 5; i++) begin
                        cmd.pre_bytes[i] = f_marker(3'(i));
                    end
                    n_match = 3'd0;
                    crb     = 1'b0;
                    n_cr    = 1'b0;
                end
                if (r_match != 3'd0 && b == B_ESC) begin
                    n_match = 3'd1;
                end else if (b == B_LF && crb) begin
                    n_cr = 1'b0;
                end else begin
                    n_cr = (b == B_CR);
                    cmd.tail_en  = 1'b1;
                    cmd.tail_rep = 5'd1;
                    if (b == B_CR || b == B_LF) begin
                        cmd.tail_code = EV_PASTE_LINE;
                    end else if (b == B_TAB) begin
                        cmd.tail_code = EV_PASTE_TEXT;
                        cmd.tail_byte = B_SPACE;
                        cmd.tail_rep  = tabn;
                    end else begin
                        cmd.tail_code = EV_PASTE_TEXT;
                        cmd.tail_byte = b;
                    end
                end
            end
        end else begin
            unique case (r_mode)
                M_UTF8: begin
                    if ((b & 8'hC0) != 8'h80) begin
                        n_cnt  = 2'd0;
                        n_owed = 2'd0;
                        do_g   = 1'b1;
                    end else if (r_owed > 2'd1 && r_cnt < 2'd3) begin
                        n_held[r_cnt] = b;
                        n_cnt  = r_cnt + 2'd1;
                        n_owed = r_owed - 2'd1;
                    end else begin
                        cmd           = f_key(EV_CHAR);
                        cmd.tail_byte = b;
                        cmd.pre_cnt   = {1'b0, r_cnt};
                        for (int i = 0; i < 3; i++) begin
                            cmd.pre_bytes[i] = r_held[i];
                        end
                        n_cnt  = 2'd0;
                        n_owed = 2'd0;
                        n_mode = M_GROUND;
                    end
                end
                M_ESC: begin
                    if (b == 8'h5b || b == 8'h4f) begin
                        n_mode = (b == 8'h5b) ? M_CSI : M_SS3;
                        n_p1   = '0;
                        n_p2   = '0;
                        n_slot = 2'd0;
                        n_odd  = 1'b0;
                    end else if (b < 8'h20 || b >= 8'h7f) begin
                        do_g = 1'b1;
                    end else begin
                        n_mode = M_GROUND;
                        if (b == 8'h62 || b == 8'h42) begin
                            cmd = f_key(EV_WORD_LEFT);
                        end else if (b == 8'h66 || b == 8'h46) begin
                            cmd = f_key(EV_WORD_RIGHT);
                        end else begin
                            cmd = f_key(EV_IGNORED);
                        end
                    end
                end
                M_CSI: begin
                    if (b >= 8'h30 && b <= 8'h39) begin
                        if (r_slot == 2'd0) begin
                            n_p1 = f_next_digit(r_p1, b[3:0]);
                        end else if (r_slot == 2'd1) begin
                            n_p2 = f_next_digit(r_p2, b[3:0]);
                        end
                    end else if (b == 8'h3b) begin
                        n_slot = (r_slot < 2'd2) ? r_slot + 2'd1 : 2'd2;
                    end else if (b >= 8'h20 && b <= 8'h3f) begin
                        n_odd = 1'b1;
                    end else if (b >= 8'h40 && b <= 8'h7e) begin
                        do_f = 1'b1;
                    end else begin
                        do_g = 1'b1;
                    end
                end
                M_SS3: begin
                    if (b >= 8'h40 && b <= 8'h7e) begin
                        do_f = 1'b1;
                    end else begin
                        do_g = 1'b1;
                    end
                end
                default: do_g = 1'b1;
            endcase
        end
        if (do_f) begin
            n_mode = M_GROUND;
            cmd = f_final(b, r_odd, (r_slot >= 2'd1) && (r_p2 == t_param'(5)), r_p1);
            if (cmd.tail_code == EV_PASTE_START) begin
                n_paste = 1'b1;
                n_match = 3'd0;
                n_cr    = 1'b0;
            end
        end
        if (do_g) begin
            cmd    = f_ground(b, tabn);
            n_mode = M_GROUND;
            if (b == B_ESC) begin
                n_mode = M_ESC;
            end else if (f_lead(b)) begin
                n_held[0] = b;
                n_cnt     = 2'd1;
                n_mode    = M_UTF8;
                if ((b & 8'hE0) == 8'hC0) begin
                    n_owed = 2'd1;
                end else if ((b & 8'hF0) == 8'hE0) begin
                    n_owed = 2'd2;
                end else begin
                    n_owed = 2'd3;
                end
            end
        end
    end

    assign o_cmd = cmd;
    assign o_has = (cmd.pre_cnt != 3'd0) || cmd.tail_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tab   <= TAB_RESET;
            r_mode  <= M_GROUND;
            r_p1    <= '0;
            r_p2    <= '0;
            r_slot  <= 2'd0;
            r_odd   <= 1'b0;
            r_cnt   <= 2'd0;
            r_owed  <= 2'd0;
            r_paste <= 1'b0;
            r_match <= 3'd0;
            r_cr    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tab <= i_cfg_data;
            end
            if (i_accept) begin
                r_mode  <= n_mode;
                r_p1    <= n_p1;
                r_p2    <= n_p2;
                r_slot  <= n_slot;
                r_odd   <= n_odd;
                r_cnt   <= n_cnt;
                r_owed  <= n_owed;
                r_paste <= n_paste;
                r_match <= n_match;
                r_cr    <= n_cr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_held <= n_held;
        end
    end

endmodule

// File: src/tkd_queue.sv
module tkd_queue
    import tkd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_cmd i_data,
    input  logic i_rd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_data
);

    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_wr) begin
                r_wp <= ~r_wp;
            end
            if (i_rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_wr} - {1'b0, i_rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// File: src/tkd_back.sv
module tkd_back
    import tkd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_cmd       i_q_data,
    output logic       o_q_rd,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [4:0] o_event_code,
    output logic [7:0] o_text_byte,
    output logic       o_last_of_run
);

    logic       r_busy;
    t_cmd       r_cmd;
    logic [2:0] r_pos;
    logic [4:0] r_rep;
    logic       in_tail, last, fire, take;

    assign in_tail = (r_pos >= r_cmd.pre_cnt);
    assign last    = in_tail ? (r_rep == r_cmd.tail_rep - 5'd1)
                             : ((r_pos == r_cmd.pre_cnt - 3'd1) && !r_cmd.tail_en);
    assign fire    = r_busy && i_pop;
    assign take    = !r_busy || (fire && last);
    assign o_q_rd  = take && i_q_valid;

    assign o_empty       = !r_busy;
    assign o_last_of_run = last;
    assign o_event_code  = in_tail ? r_cmd.tail_code
                                   : (r_cmd.pre_paste ? EV_PASTE_TEXT : EV_CHAR);
    assign o_text_byte   = in_tail ? r_cmd.tail_byte : r_cmd.pre_bytes[r_pos];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos  <= 3'd0;
            r_rep  <= 5'd0;
        end else if (take) begin
            r_busy <= i_q_valid;
            r_pos  <= 3'd0;
            r_rep  <= 5'd0;
        end else if (fire) begin
            if (in_tail) begin
                r_rep <= r_rep + 5'd1;
            end else begin
                r_pos <= r_pos + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd <= i_q_data;
        end
    end

endmodule

// File: src/terminal_key_decoder.sv
// Terminal key decoder: raw terminal bytes in, key and text events out.
// Input side is a queue: drive i_in_byte and push; the beat is taken on a
// rising edge with push high and full low. Output side is a queue too: the
// oldest event sits on o_event_code, o_text_byte and o_last_of_run while
// empty is low, and pop high at a rising edge takes that beat.
// One byte is accepted per cycle while full is low. A byte that yields events
// goes through the command queue and the back end's command register before
// its first event shows on the output; the back end delivers one event per
// cycle while pop is high, so a byte that expands to k events (a tab, a UTF-8
// character, a broken paste end marker) takes k pops; the two-entry command
// queue between parser and expander sets how far input may run ahead.
// i_cfg_we with i_cfg_data sets the tab width; write it only while idle.
// A synchronous low on i_rst_n empties both queues, returns the parser to its
// ground state and sets the tab width to eight. When the receiver stops
// popping, the queue fills and full rises; no event is dropped.
`include "terminal_key_decoder_defines.svh"

module terminal_key_decoder
    import tkd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    output logic       empty,
    input  logic       pop,
    output logic [4:0] o_event_code,
    output logic [7:0] o_text_byte,
    output logic       o_last_of_run,
    input  logic       i_cfg_we,
    input  logic [4:0] i_cfg_data
);

    logic accept, has, q_valid, q_rd;
    t_cmd cmd, q_data;

    assign accept = push && !full;

    tkd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_in_byte  (i_in_byte),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_cmd      (cmd),
        .o_has      (has)
    );

    tkd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (accept && has),
        .i_data  (cmd),
        .i_rd    (q_rd),
        .o_full  (full),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    tkd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_data      (q_data),
        .o_q_rd        (q_rd),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_event_code  (o_event_code),
        .o_text_byte   (o_text_byte),
        .o_last_of_run (o_last_of_run)
    );

    `TKD_ASSERT(a_key_no_byte, i_clk, i_rst_n,
        (!empty && o_event_code > EV_PASTE_TEXT) |-> (o_text_byte == 8'd0),
        "key event carries a text byte")
    `TKD_ASSERT(a_code_range, i_clk, i_rst_n,
        !empty |-> (o_event_code <= EV_PASTE_LINE), "event code out of range")
    `TKD_ASSERT(a_full_has_data, i_clk, i_rst_n,
        full |-> (q_valid && !empty), "queue full while back end idle")
    `TKD_ASSERT_NORST(a_reset_empty, i_clk,
        $past(!i_rst_n) |-> (empty && !full), "not empty after reset")

endmodule

// File: verif/tb_terminal_key_decoder.sv
module tb_terminal_key_decoder;
    import tkd_pkg::*;

    typedef enum logic [2:0] {
        PM_GROUND = 3'd0,
        PM_ESC    = 3'd1,
        PM_UTF8   = 3'd2,
        PM_CSI    = 3'd3,
        PM_SS3    = 3'd4
    } t_pmode;

    typedef struct packed {
        logic [4:0] code;
        logic [7:0] data;
        logic       last;
    } t_event;

    typedef struct {
        logic [7:0] b;
        bit         known;
        logic [4:0] code;
        logic [7:0] data;
    } t_row;

    localparam int LIMIT = 400000;

    logic       i_clk;
    logic       i_rst_n;
    logic       push;
    logic       full;
    logic [7:0] i_in_byte;
    logic       empty;
    logic       pop;
    logic [4:0] o_event_code;
    logic [7:0] o_text_byte;
    logic       o_last_of_run;
    logic       i_cfg_we;
    logic [4:0] i_cfg_data;

    terminal_key_decoder DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_in_byte(i_in_byte), .empty(empty), .pop(pop),
        .o_event_code(o_event_code), .o_text_byte(o_text_byte),
        .o_last_of_run(o_last_of_run), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    t_event     events_due[$];
    int         errors = 0;
    int         cycles = 0;
    int         bytes_sent = 0;
    int         events_seen = 0;
    int         send_idle = 0;
    int         recv_stall = 0;

    logic [4:0] tab_reg;
    t_pmode     mode;
    int         par1, par2, slot;
    bit         odd;
    logic [7:0] held[3];
    int         held_cnt, owed;
    bit         pasting;
    int         match_len;
    bit         cr_prev;
    t_event     burst[$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb_terminal_key_decoder NOT OK");
            $finish;
        end
    end

    function automatic logic [7:0] marker_byte(int k);
        case (k)
            0: return B_ESC;
            1: return 8'h5b;
            2: return 8'h32;
            3: return 8'h30;
            4: return 8'h31;
            default: return 8'h7e;
        endcase
    endfunction

    function automatic int step_param(int p, logic [7:0] d);
        int v;
        if (p >= PARAM_CAP) return PARAM_CAP;
        v = p * 10 + (d - 8'h30);
        return v > PARAM_CAP ? PARAM_CAP : v;
    endfunction

    function automatic int spaces_per_tab();
        if (tab_reg < 1) return 1;
        if (tab_reg > 16) return 16;
        return tab_reg;
    endfunction

    task automatic emit(logic [4:0] c, logic [7:0] d);
        t_event e;
        e.code = c;
        e.data = d;
        e.last = 1'b0;
        burst.push_back(e);
    endtask

    task automatic decoder_reset();
        tab_reg = TAB_RESET;
        mode = PM_GROUND;
        par1 = 0; par2 = 0; slot = 0; odd = 0;
        held_cnt = 0; owed = 0;
        pasting = 0; match_len = 0; cr_prev = 0;
    endtask

    task automatic ground_byte(logic [7:0] b);
        int n;
        mode = PM_GROUND;
        case (b)
            B_ESC: begin mode = PM_ESC; return; end
            B_CR, B_LF: begin emit(EV_ENTER, 0); return; end
            8'h7f, 8'h08: begin emit(EV_BACKSPACE, 0); return; end
            8'h03: begin emit(EV_INTERRUPT, 0); return; end
            8'h04: begin emit(EV_EOF, 0); return; end
            8'h01: begin emit(EV_HOME, 0); return; end
            8'h05: begin emit(EV_END, 0); return; end
            8'h02: begin emit(EV_LEFT, 0); return; end
            8'h06: begin emit(EV_RIGHT, 0); return; end
            8'h10: begin emit(EV_UP, 0); return; end
            8'h0e: begin emit(EV_DOWN, 0); return; end
            8'h15: begin emit(EV_KILL_START, 0); return; end
            8'h0b: begin emit(EV_KILL_END, 0); return; end
            8'h17: begin emit(EV_KILL_WORD, 0); return; end
            8'h0c: begin emit(EV_CLEAR, 0); return; end
            B_TAB: begin
                for (int i = 0; i < spaces_per_tab(); i++) emit(EV_CHAR, B_SPACE);
                return;
            end
            default: ;
        endcase
        if (b < 8'h20) begin emit(EV_IGNORED, 0); return; end
        if (b < 8'h80) n = 1;
        else if ((b & 8'he0) == 8'hc0) n = 2;
        else if ((b & 8'hf0) == 8'he0) n = 3;
        else if ((b & 8'hf8) == 8'hf0) n = 4;
        else n = 0;
        if (n == 0) emit(EV_IGNORED, 0);
        else if (n == 1) emit(EV_CHAR, b);
        else begin
            held[0] = b;
            held_cnt = 1;
            owed = n - 1;
            mode = PM_UTF8;
        end
    endtask

    task automatic csi_final(logic [7:0] b);
        bit ctl;
        ctl = slot >= 1 && par2 == 5;
        if (odd) begin emit(EV_IGNORED, 0); return; end
        case (b)
            8'h41: begin emit(EV_UP, 0); return; end
            8'h42: begin emit(EV_DOWN, 0); return; end
            8'h43: begin emit(ctl ? EV_WORD_RIGHT : EV_RIGHT, 0); return; end
            8'h44: begin emit(ctl ? EV_WORD_LEFT : EV_LEFT, 0); return; end
            8'h48: begin emit(EV_HOME, 0); return; end
            8'h46: begin emit(EV_END, 0); return; end
            8'h7e: ;
            default: begin emit(EV_IGNORED, 0); return; end
        endcase
        case (par1)
            1, 7: emit(EV_HOME, 0);
            4, 8: emit(EV_END, 0);
            3: emit(EV_DELETE, 0);
            200: begin
                pasting = 1;
                match_len = 0;
                cr_prev = 0;
                emit(EV_PASTE_START, 0);
            end
            default: emit(EV_IGNORED, 0);
        endcase
    endtask

    task automatic paste_byte(logic [7:0] b);
        if (match_len < 6 && b == marker_byte(match_len)) begin
            match_len++;
            if (match_len < 6) return;
            pasting = 0;
            match_len = 0;
            cr_prev = 0;
            emit(EV_PASTE_END, 0);
            return;
        end
        if (match_len > 0) begin
            for (int i = 0; i < match_len; i++) emit(EV_PASTE_TEXT, marker_byte(i));
            match_len = 0;
            cr_prev = 0;
            if (b == B_ESC) begin
                match_len = 1;
                return;
            end
        end
        if (b == B_LF && cr_prev) begin
            cr_prev = 0;
            return;
        end
        cr_prev = (b == B_CR);
        if (b == B_CR || b == B_LF) emit(EV_PASTE_LINE, 0);
        else if (b == B_TAB) begin
            for (int i = 0; i < spaces_per_tab(); i++) emit(EV_PASTE_TEXT, B_SPACE);
        end else emit(EV_PASTE_TEXT, b);
    endtask

    // Works out the events that one byte causes and queues them.
    task automatic decode_byte(logic [7:0] b);
        burst.delete();
        if (pasting) paste_byte(b);
        else if (mode == PM_UTF8) begin
            if ((b & 8'hc0) != 8'h80) begin
                held_cnt = 0;
                owed = 0;
                ground_byte(b);
            end else if (owed > 1 && held_cnt < 3) begin
                held[held_cnt] = b;
                held_cnt++;
                owed--;
            end else begin
                for (int i = 0; i < held_cnt; i++) emit(EV_CHAR, held[i]);
                emit(EV_CHAR, b);
                held_cnt = 0;
                owed = 0;
                mode = PM_GROUND;
            end
        end else if (mode == PM_ESC) begin
            if (b == 8'h5b || b == 8'h4f) begin
                mode = (b == 8'h5b) ? PM_CSI : PM_SS3;
                par1 = 0; par2 = 0; slot = 0; odd = 0;
            end else if (b < 8'h20 || b >= 8'h7f) ground_byte(b);
            else begin
                mode = PM_GROUND;
                if (b == 8'h62 || b == 8'h42) emit(EV_WORD_LEFT, 0);
                else if (b == 8'h66 || b == 8'h46) emit(EV_WORD_RIGHT, 0);
                else emit(EV_IGNORED, 0);
            end
        end else if (mode == PM_CSI) begin
            if (b >= 8'h30 && b <= 8'h39) begin
                if (slot == 0) par1 = step_param(par1, b);
                else if (slot == 1) par2 = step_param(par2, b);
            end else if (b == 8'h3b) slot = slot < 2 ? slot + 1 : 2;
            else if (b >= 8'h20 && b <= 8'h3f) odd = 1;
            else if (b >= 8'h40 && b <= 8'h7e) begin
                mode = PM_GROUND;
                csi_final(b);
            end else ground_byte(b);
        end else if (mode == PM_SS3) begin
            if (b >= 8'h40 && b <= 8'h7e) begin
                mode = PM_GROUND;
                csi_final(b);
            end else ground_byte(b);
        end else ground_byte(b);
        if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
        foreach (burst[i]) events_due.push_back(burst[i]);
    endtask

    task automatic send_byte(logic [7:0] b);
        while (send_idle > 0 && $urandom_range(99) < send_idle) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push <= 1'b1;
        i_in_byte <= b;
        do @(posedge i_clk); while (full);
        decode_byte(b);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (events_due.size() > 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic set_tab(logic [4:0] v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        tab_reg = v;
    endtask

    task automatic send_str(string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(255));
    endfunction

    // A well-formed sequence with random content, now and then broken or noise.
    task automatic random_chunk();
        int k;
        string finals;
        finals = "ABCDHF~";
        k = $urandom_range(11);
        case (k)
            0: send_byte(any_byte());
            1: send_byte(8'($urandom_range(31)));
            2: begin
                send_byte(B_ESC);
                send_byte(8'h5b);
                send_str($sformatf("%0d", $urandom_range(9)));
                if ($urandom_range(1)) send_str($sformatf(";%0d", $urandom_range(6)));
                send_byte(finals[$urandom_range(6)]);
            end
            3: begin
                send_byte(B_ESC);
                send_byte($urandom_range(1) ? 8'h4f : 8'h5b);
                send_byte(8'($urandom_range(8'h20, 8'h7e)));
                if ($urandom_range(1)) send_byte(8'($urandom_range(8'h40, 8'h7e)));
            end
            4: begin
                send_byte(B_ESC);
                send_byte(any_byte());
            end
            5: begin
                send_byte(8'($urandom_range(8'hc0, 8'hf7)));
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(8'h80, 8'hbf)));
            end
            6: begin
                send_byte(8'($urandom_range(8'hc0, 8'hf7)));
                send_byte(any_byte());
            end
            7: send_str("\x1b[1;5C");
            8, 9: begin
                send_str("\x1b[200~");
                repeat ($urandom_range(1, 8)) begin
                    case ($urandom_range(5))
                        0: send_byte(B_CR);
                        1: send_byte(B_LF);
                        2: send_byte(B_TAB);
                        3: send_str("\x1b[20");
                        default: send_byte(any_byte());
                    endcase
                end
                send_str("\x1b[201~");
            end
            10: send_byte(B_TAB);
            default: send_byte(8'($urandom_range(8'h20, 8'h7e)));
        endcase
    endtask

    initial begin
        pop = 1'b0;
        recv_stall = 0;
        forever begin
            @(negedge i_clk);
            pop <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);
        end
    end

    always @(posedge i_clk) begin
        t_event got, want;
        if (i_rst_n && pop && !empty) begin
            got.code = o_event_code;
            got.data = o_text_byte;
            got.last = o_last_of_run;
            events_seen++;
            if (events_due.size() == 0) begin
                $error("unexpected beat: code %0d byte %0h", got.code, got.data);
                errors++;
            end else begin
                want = events_due.pop_front();
                if (got.code !== want.code) begin
                    $error("event_code: expected %0d, got %0d", want.code, got.code);
                    errors++;
                end
                if (got.data !== want.data) begin
                    $error("text_byte: expected %0h, got %0h", want.data, got.data);
                    errors++;
                end
                if (got.last !== want.last) begin
                    $error("last_of_run: expected %0d, got %0d", want.last, got.last);
                    errors++;
                end
            end
        end
    end

    t_row rows[$];

    task automatic add_row(logic [7:0] b, bit k, logic [4:0] c, logic [7:0] d);
        t_row r;
        r.b = b; r.known = k; r.code = c; r.data = d;
        rows.push_back(r);
    endtask

    initial begin
        int idle_s[4];
        int idle_r[4];
        t_event peek;
        idle_s = '{0, 69, 0, 37};
        idle_r = '{0, 0, 69, 37};
        i_rst_n = 1'b0;
        push = 1'b0;
        i_in_byte = 8'h00;
        i_cfg_we = 1'b0;
        i_cfg_data = 5'd0;
        decoder_reset();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        add_row(8'h00, 1, EV_IGNORED, 0);
        add_row(8'h7f, 1, EV_BACKSPACE, 0);
        add_row(8'hff, 1, EV_IGNORED, 0);
        add_row(8'h41, 1, EV_CHAR, 8'h41);
        add_row(8'h0d, 1, EV_ENTER, 0);
        add_row(8'h80, 1, EV_IGNORED, 0);
        add_row(8'h09, 0, 0, 0);
        add_row(8'h1b, 0, 0, 0);
        add_row(8'h62, 1, EV_WORD_LEFT, 0);
        add_row(8'h1b, 0, 0, 0);
        add_row(8'h5b, 0, 0, 0);
        add_row(8'h39, 0, 0, 0);
        add_row(8'h39, 0, 0, 0);
        add_row(8'h39, 0, 0, 0);
        add_row(8'h39, 0, 0, 0);
        add_row(8'h7e, 1, EV_IGNORED, 0);
        add_row(8'h1b, 0, 0, 0);
        add_row(8'h4f, 0, 0, 0);
        add_row(8'h03, 1, EV_INTERRUPT, 0);
        add_row(8'hf0, 0, 0, 0);
        add_row(8'h9f, 0, 0, 0);
        add_row(8'h41, 1, EV_CHAR, 8'h41);
        foreach (rows[i]) begin
            send_byte(rows[i].b);
            if (rows[i].known) begin
                peek = events_due[events_due.size() - 1];
                if (peek.code !== rows[i].code) begin
                    $error("event_code: expected %0d, got %0d", rows[i].code, peek.code);
                    errors++;
                end
                if (peek.data !== rows[i].data) begin
                    $error("text_byte: expected %0h, got %0h", rows[i].data, peek.data);
                    errors++;
                end
            end
        end
        send_str("\x1b[200~a\x1b[20x\r\n\t\x1b\x1b[201~");
        send_str("\x1b[3~\x1b[1;5D\x1b[?1~\x1b[1;2;3C");

        for (int ph = 0; ph < 4; ph++) begin
            set_tab(ph == 0 ? 5'd16 : ph == 1 ? 5'd1 : ph == 2 ? 5'd0 : 5'd31);
            send_idle = idle_s[ph];
            recv_stall = idle_r[ph];
            repeat (10) random_chunk();
            send_idle = 0;
            drain();
            repeat (10) send_byte(B_TAB);
        end
        recv_stall = 0;
        drain();
        $display("Sent %0d bytes and checked %0d events over four idling phases",
                 bytes_sent, events_seen);
        $display("and tab widths 0, 1, 16 and 31.");
        if (errors == 0 && events_due.size() == 0) begin
            $display("tb_terminal_key_decoder OK");
        end else begin
            $display("tb_terminal_key_decoder NOT OK");
        end
        $finish;
    end
endmodule
